/* rtl/assert_macros.svh */
// assertion macros used by set_assoc_lru_cache_tags_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// types and constants of the set-associative tag unit
// ----------------------------------------------------------------------------
package salc_pkg;
	localparam int MAX_INDEX_BITS = 6;
	localparam int WAYS = 8;
	localparam int SETS = 1 << MAX_INDEX_BITS;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
	localparam int WCNT_W = $clog2(WAYS + 1);
	localparam int TAG_TOP_BIT = 31;

	localparam logic [1:0] CFG_OFFSET = 2'd0;
	localparam logic [1:0] CFG_INDEX = 2'd1;
	localparam logic [1:0] CFG_WAYS = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
	} cmd_t;
endpackage

/* rtl/salc_ctrl.sv */
// ----------------------------------------------------------------------------
// salc_ctrl
// sequencer: accept request, read set, write back, present result
// ----------------------------------------------------------------------------
module salc_ctrl import salc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd
);
	state_t state_q, state_d;
	logic   ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ov_d = ov_q;
		cmd = '0;
		in_ready = 1'b0;
		if (ov_q && out_ready) ov_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!ov_q || out_ready) begin
					cmd.update = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;
endmodule

/* rtl/salc_dp.sv */
// ----------------------------------------------------------------------------
// salc_dp
// set store, way compare, victim select, counters
// ----------------------------------------------------------------------------
module salc_dp import salc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        req_type,
	input  logic [31:0] address,
	input  logic [31:0] stamp,
	input  logic        first_word,
	output logic        hit,
	output logic [2:0]  way,
	output logic        evicted_dirty,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] dirty_evictions
);
	logic [4:0] off_q;
	logic [2:0] idx_q;
	logic [3:0] ways_q;
	logic [WAYS-1:0][31:0] tag_mem [SETS];
	logic [WAYS-1:0][31:0] stp_mem [SETS];
	logic [WAYS-1:0] vld_q [SETS];
	logic [WAYS-1:0] drt_q [SETS];
	logic [WAYS-1:0][31:0] tag_row_s1;
	logic [WAYS-1:0][31:0] stp_row_s1;
	logic [WAYS-1:0] vld_s1, drt_s1;
	logic [SET_W-1:0] set_s1;
	logic [31:0] tag_s1, now_s1;
	logic wr_s1, wms_q, wms_s1;
	logic [31:0] hit_cnt_q, miss_cnt_q, dev_cnt_q;

	logic [2:0] eidx;
	logic [WCNT_W-1:0] ewy;
	logic [5:0] tsh;
	logic [SET_W-1:0] set_c;
	logic [31:0] tag_c, shifted;

	always_comb begin
		eidx = (idx_q > 3'(MAX_INDEX_BITS)) ? 3'(MAX_INDEX_BITS) : idx_q;
		if (ways_q == 4'd0) ewy = WCNT_W'(1);
		else if (ways_q > 4'(WAYS)) ewy = WCNT_W'(WAYS);
		else ewy = WCNT_W'(ways_q);
		shifted = address >> off_q;
		set_c = SET_W'(shifted & ((32'd1 << eidx) - 32'd1));
		tsh = 6'(off_q) + 6'(eidx);
		tag_c = (tsh > 6'(TAG_TOP_BIT)) ? 32'd0 : (address >> tsh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 5'd2;
			idx_q <= 3'd0;
			ways_q <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OFFSET: off_q <= cfg_data;
				CFG_INDEX: idx_q <= cfg_data[2:0];
				CFG_WAYS: ways_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// registered set read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_row_s1 <= tag_mem[set_c];
			stp_row_s1 <= stp_mem[set_c];
			set_s1 <= set_c;
			tag_s1 <= tag_c;
			now_s1 <= stamp;
			wr_s1 <= req_type;
			vld_s1 <= vld_q[set_c];
			drt_s1 <= drt_q[set_c];
		end
	end

	logic fnd, placed, have;
	logic [WAY_W-1:0] hw, fw, vw, sel;
	logic [32:0] oldest;

	always_comb begin
		fnd = 1'b0; hw = '0; placed = 1'b0; fw = '0;
		have = 1'b0; vw = '0; oldest = {1'b0, now_s1} + 33'd1;
		for (int w = 0; w < WAYS; w++) begin
			if (WCNT_W'(w) < ewy) begin
				if (!fnd && vld_s1[w] && tag_row_s1[w] == tag_s1) begin
					fnd = 1'b1; hw = WAY_W'(w);
				end
				if (!placed && !vld_s1[w]) begin
					placed = 1'b1; fw = WAY_W'(w);
				end
				if ({1'b0, stp_row_s1[w]} < oldest) begin
					oldest = {1'b0, stp_row_s1[w]}; vw = WAY_W'(w); have = 1'b1;
				end
			end
		end
		sel = fnd ? hw : (placed ? fw : vw);
	end

	logic wms_eff, cnt_miss, evd_c;
	assign wms_eff = wms_q && !wms_s1;
	assign cnt_miss = !fnd && (!wr_s1 || !wms_eff);
	assign evd_c = !fnd && !placed && have && drt_s1[vw];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				vld_q[s] <= '0;
				drt_q[s] <= '0;
			end
			hit_cnt_q <= '0; miss_cnt_q <= '0; dev_cnt_q <= '0;
			wms_q <= 1'b0; wms_s1 <= 1'b0;
			hit <= 1'b0; way <= '0; evicted_dirty <= 1'b0;
		end else begin
			if (cmd.load) wms_s1 <= first_word;
			if (cmd.update) begin
				hit <= fnd;
				way <= 3'(sel);
				evicted_dirty <= evd_c;
				if (fnd) begin
					if (wr_s1) drt_q[set_s1][hw] <= 1'b1;
					else hit_cnt_q <= hit_cnt_q + 32'd1;
				end else begin
					if (placed) vld_q[set_s1][fw] <= 1'b1;
					else if (have) drt_q[set_s1][vw] <= 1'b0;
				end
				if (cnt_miss) miss_cnt_q <= miss_cnt_q + 32'd1;
				if (evd_c) dev_cnt_q <= dev_cnt_q + 32'd1;
				if (!fnd && wr_s1) wms_q <= 1'b1;
				else if (wms_s1) wms_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && (fnd || placed || have)) begin
			stp_mem[set_s1][sel] <= now_s1;
			if (!fnd) tag_mem[set_s1][sel] <= tag_s1;
		end
	end

	assign hit_total = hit_cnt_q;
	assign miss_total = miss_cnt_q;
	assign dirty_evictions = dev_cnt_q;
endmodule

/* rtl/set_assoc_lru_cache_tags_unit.sv */
// accepted request: set read into registers, then write-back registers the result
// a new request is accepted only after the write-back of the previous one
// a request accepted while a result waits holds its write-back until the output frees
// asynchronous reset clears valid bits, dirty bits and counters, restores config defaults
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_unit
// tag, valid, dirty and lru stamp store of a set-associative cache
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module set_assoc_lru_cache_tags_unit import salc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] address,
	input  logic [31:0] stamp,
	input  logic        first_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [2:0]  way,
	output logic        evicted_dirty,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] dirty_evictions
);
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	salc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	salc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_valid(cfg_valid),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .req_type(req_type),
		.address(address), .stamp(stamp), .first_word(first_word), .hit(hit),
		.way(way), .evicted_dirty(evicted_dirty), .hit_total(hit_total),
		.miss_total(miss_total), .dirty_evictions(dirty_evictions)
	);

	`ASSERT_NEXT(a_load_update, clk, arst_n, cmd.load, !in_ready)
	`ASSERT_IMPL(a_cmd_excl, clk, arst_n, cmd.load, !cmd.update)
	`ASSERT_NEXT(a_upd_valid, clk, arst_n, cmd.update, out_valid)
	`ASSERT_IMPL(a_evd_miss, clk, arst_n, out_valid && evicted_dirty, !hit)
endmodule

/* tb/tb_set_assoc_lru_cache_tags_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tags_unit
// checks lookups, fills, lru replacement, dirty eviction and statistics of the
// tag unit against a behavioral cache model, under random idling on both sides
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tags_unit;
	import salc_pkg::*;

	typedef struct packed {
		logic        hit;
		logic [2:0]  way;
		logic        evicted_dirty;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] dirty_evictions;
	} lookup_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_OFFSET;
	logic [4:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic req_type = 0;
	logic [31:0] address = 0;
	logic [31:0] stamp = 0;
	logic first_word = 0;
	logic out_valid;
	logic out_ready = 0;
	logic hit;
	logic [2:0] way;
	logic evicted_dirty;
	logic [31:0] hit_total, miss_total, dirty_evictions;

	set_assoc_lru_cache_tags_unit uut (.*);

	// cache model state
	logic [31:0] m_tag [SETS*WAYS];
	logic m_valid [SETS*WAYS];
	logic m_dirty [SETS*WAYS];
	logic [31:0] m_stamp [SETS*WAYS];
	logic [31:0] m_hits, m_misses, m_devict;
	logic m_wmiss_seen;
	logic [4:0] m_offset;
	logic [2:0] m_index;
	logic [3:0] m_ways;

	lookup_t expected_lookups[$];
	logic [31:0] now_stamp = 0;
	int errors = 0;
	int cycles = 0;
	bit rx_hold = 0;
	bit rx_calm = 0;
	bit tx_calm = 0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void model_clear();
		for (int k = 0; k < SETS*WAYS; k++) begin
			m_tag[k] = 0;
			m_valid[k] = 0;
			m_dirty[k] = 0;
			m_stamp[k] = 0;
		end
		m_hits = 0;
		m_misses = 0;
		m_devict = 0;
		m_wmiss_seen = 0;
		m_offset = 2;
		m_index = 0;
		m_ways = 1;
	endfunction

	function automatic lookup_t model_access(logic wr, logic [31:0] a, logic [31:0] t,
			logic first);
		lookup_t r;
		int s, e, set, tsh, base, victim;
		logic [31:0] tg;
		logic [32:0] oldest;
		bit found, placed, have;
		s = (m_index > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(m_index);
		e = (m_ways < 1) ? 1 : (m_ways > WAYS) ? WAYS : int'(m_ways);
		set = int'(32'((64'(a) >> m_offset) & 64'((1 << s) - 1)));
		tsh = int'(m_offset) + s;
		tg = (tsh > TAG_TOP_BIT) ? 32'd0 : (a >> tsh);
		base = set * WAYS;
		r = '0;
		found = 0;
		placed = 0;
		if (first)
			m_wmiss_seen = 0;
		for (int i = 0; i < e && !found; i++) begin
			if (m_valid[base+i] && m_tag[base+i] == tg) begin
				found = 1;
				r.way = 3'(i);
				m_stamp[base+i] = t;
			end
		end
		if (found) begin
			r.hit = 1;
			if (wr)
				m_dirty[base+r.way] = 1;
			else
				m_hits++;
		end else begin
			if (!wr || !m_wmiss_seen)
				m_misses++;
			if (wr)
				m_wmiss_seen = 1;
			for (int i = 0; i < e && !placed; i++) begin
				if (!m_valid[base+i]) begin
					m_valid[base+i] = 1;
					m_tag[base+i] = tg;
					m_stamp[base+i] = t;
					r.way = 3'(i);
					placed = 1;
				end
			end
			if (!placed) begin
				oldest = {1'b0, t} + 33'd1;
				have = 0;
				victim = 0;
				for (int i = 0; i < e; i++) begin
					if ({1'b0, m_stamp[base+i]} < oldest) begin
						oldest = {1'b0, m_stamp[base+i]};
						victim = i;
						have = 1;
					end
				end
				if (have) begin
					if (m_dirty[base+victim]) begin
						m_devict++;
						r.evicted_dirty = 1;
					end
					m_dirty[base+victim] = 0;
					m_tag[base+victim] = tg;
					m_stamp[base+victim] = t;
					r.way = 3'(victim);
				end
			end
		end
		r.hit_total = m_hits;
		r.miss_total = m_misses;
		r.dirty_evictions = m_devict;
		return r;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_OFFSET: m_offset = val;
			CFG_INDEX: m_index = val[2:0];
			CFG_WAYS: m_ways = val[3:0];
			default: ;
		endcase
	endtask

	task automatic send_access(logic wr, logic [31:0] a, logic first, int adv = 1);
		if (!tx_calm)
			while ($urandom_range(99) < 25) begin
				in_valid <= 0;
				@(posedge clk);
			end
		if (now_stamp < 32'hFFFF_FFF0 - 32'(adv))
			now_stamp = now_stamp + 32'(adv);
		in_valid <= 1;
		req_type <= wr;
		address <= a;
		stamp <= now_stamp;
		first_word <= first;
		do @(posedge clk); while (!in_ready);
		expected_lookups.push_back(model_access(wr, a, now_stamp, first));
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 0;
		while (expected_lookups.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(logic [4:0] off, logic [2:0] idx, logic [3:0] w);
		drain();
		write_reg(CFG_OFFSET, off);
		write_reg(CFG_INDEX, {2'b0, idx});
		write_reg(CFG_WAYS, {1'b0, w});
		cfg_valid <= 0;
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_lookups.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				lookup_t x;
				x = expected_lookups.pop_front();
				if (hit !== x.hit) begin
					$error("hit exp %0d got %0d", x.hit, hit);
					errors++;
				end
				if (way !== x.way) begin
					$error("way exp %0d got %0d", x.way, way);
					errors++;
				end
				if (evicted_dirty !== x.evicted_dirty) begin
					$error("evicted_dirty exp %0d got %0d", x.evicted_dirty, evicted_dirty);
					errors++;
				end
				if (hit_total !== x.hit_total) begin
					$error("hit_total exp %0d got %0d", x.hit_total, hit_total);
					errors++;
				end
				if (miss_total !== x.miss_total) begin
					$error("miss_total exp %0d got %0d", x.miss_total, miss_total);
					errors++;
				end
				if (dirty_evictions !== x.dirty_evictions) begin
					$error("dirty_evictions exp %0d got %0d", x.dirty_evictions,
						dirty_evictions);
					errors++;
				end
			end
		end
		out_ready <= !rx_hold && (rx_calm || $urandom_range(99) >= 25);
	end

	// directed: extremes, hits, fills, lru, dirty eviction, no older way
	task automatic test_directed();
		configure(2, 1, 2);
		send_access(0, 32'h0000_0000, 1);
		send_access(0, 32'h0000_0000, 1);
		send_access(1, 32'hFFFF_FFFF, 1);
		send_access(1, 32'hFFFF_FFFF, 0);
		send_access(1, 32'h0000_0010, 0);
		send_access(1, 32'h0000_0020, 0);
		send_access(0, 32'h0000_0040, 1);
		send_access(0, 32'h0000_0008, 1);
		send_access(0, 32'h0000_1008, 1);
		send_access(0, 32'h0000_2008, 1);
		send_access(1, 32'h0000_2008, 1);
		send_access(0, 32'h0000_3008, 1);
		send_access(0, 32'h0000_4008, 1);
		// stamp near maximum cases and no older way
		configure(2, 0, 1);
		send_access(0, 32'h0000_0100, 1);
		now_stamp = 32'hFFFF_FFE0;
		send_access(0, 32'h0000_0200, 1, 0);
		now_stamp = 5;
		send_access(0, 32'h0000_0300, 1, 0);
		now_stamp = 32'hFFFF_FFE0;
		// wide split and saturating fields
		configure(24, 7, 15);
		send_access(0, 32'hABCD_1234, 1);
		send_access(1, 32'h1234_5678, 1);
		configure(31, 6, 0);
		send_access(0, 32'h8000_0000, 1);
		send_access(0, 32'h0000_0001, 1);
		configure(0, 0, 8);
		send_access(1, 32'h5555_5555, 1);
		send_access(0, 32'hAAAA_AAAA, 1);
		drain();
	endtask

	task automatic random_burst(int n, int hot_tags);
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			a = $urandom;
			if ($urandom_range(9) < 8) begin
				a[31:8] = 24'($urandom_range(hot_tags - 1));
				a[31] = 1'($urandom_range(1));
			end
			send_access(1'($urandom_range(1)), a, $urandom_range(3) == 0,
				int'($urandom_range(3)));
		end
	endtask

	task automatic test_random();
		now_stamp = 0;
		configure(2, 2, 4);
		random_burst(150, 12);
		configure(4, 1, 8);
		random_burst(150, 20);
		configure(0, 3, 3);
		rx_calm = 1;
		tx_calm = 1;
		random_burst(100, 8);
		rx_calm = 0;
		tx_calm = 0;
		configure(5, 0, 1);
		random_burst(100, 4);
		configure(6, 6, 2);
		random_burst(100, 30);
	endtask

	task automatic test_backpressure();
		configure(2, 1, 4);
		fork
			begin
				rx_hold = 1;
				repeat (60) @(posedge clk);
				rx_hold = 0;
			end
			random_burst(20, 6);
		join
		drain();
		random_burst(10, 6);
	endtask

	initial begin
		model_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
